// ===== rtl/core/iso_timestamp_to_epoch_assert.svh =====
// Assertion macros for the ISO-8601 timestamp converter.
// Used by iso_timestamp_to_epoch.sv; no other dependencies.
`ifndef ISO_TIMESTAMP_TO_EPOCH_ASSERT_SVH
`define ISO_TIMESTAMP_TO_EPOCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ITE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iso_timestamp_to_epoch: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ITE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iso_timestamp_to_epoch: next-cycle check failed");

`endif

// ===== rtl/core/isots_pkg.sv =====
// Shared types and constants of the ISO-8601 timestamp converter.
// No dependencies; used by iso_timestamp_to_epoch.sv.
package isots_pkg;

   // Beat payloads
   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [63:0] epoch_seconds;
      logic [1:0]         status;
   } rsp_type;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_SHORT   = 2'd1;
   localparam logic [1:0] ST_BAD_SEP = 2'd2;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [8:0] DIGIT_BIAS = 9'd48;

   // Character positions in the fixed frame YYYY-MM-DDTHH:MM:SS
   localparam logic [4:0] POS_DASH1     = 5'd4;
   localparam logic [4:0] POS_DASH2     = 5'd7;
   localparam logic [4:0] POS_SEP_T     = 5'd10;
   localparam logic [4:0] POS_COLON1    = 5'd13;
   localparam logic [4:0] POS_COLON2    = 5'd16;
   localparam logic [4:0] POS_LAST_MAIN = 5'd18;
   localparam logic [4:0] MAIN_LEN      = 5'd19;
   localparam logic [4:0] POS_SAT       = 5'd31;

   // Offset digit count
   localparam logic [2:0] OFF_HALF   = 3'd2;
   localparam logic [2:0] OFF_DIGITS = 3'd4;

   // Field and datapath widths
   localparam int YEAR_W  = 19;
   localparam int FIELD_W = 13;
   localparam int TEN_W   = 20;
   localparam int MUL_A_W = 29;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DAYS_W  = 28;

   // Calendar arithmetic constants
   localparam logic signed [TEN_W-1:0]   ERA_BIAS_YEARS = 20'sd80000;  // 200 eras
   localparam logic signed [10:0]        ERA_BIAS       = 11'sd200;
   localparam logic signed [DAYS_W-1:0]  EPOCH_DAY_OFS  = 28'sd719468;
   localparam logic signed [MUL_B_W-1:0] DIV400_MUL     = 21'sd671089; // ceil(2^28/400)
   localparam int                        DIV400_SHIFT   = 28;
   localparam logic signed [MUL_B_W-1:0] DIV5_MUL       = 21'sd419431; // ceil(2^21/5)
   localparam int                        DIV5_SHIFT     = 21;
   localparam logic signed [MUL_B_W-1:0] YEARS_PER_ERA  = 21'sd400;
   localparam logic signed [MUL_B_W-1:0] MONTH_MUL      = 21'sd153;
   localparam logic signed [MUL_B_W-1:0] DAYS_PER_YEAR  = 21'sd365;
   localparam logic signed [MUL_B_W-1:0] DAYS_PER_ERA   = 21'sd146097;
   localparam logic signed [MUL_B_W-1:0] SEC_PER_DAY    = 21'sd86400;
   localparam logic signed [MUL_B_W-1:0] SEC_PER_HOUR   = 21'sd3600;
   localparam logic signed [MUL_B_W-1:0] SEC_PER_MIN    = 21'sd60;

   // acc * 10 + digit, two shifts and adds
   function automatic logic signed [TEN_W-1:0] times_ten_plus(
      input logic signed [TEN_W-1:0] acc,
      input logic signed [8:0]       digit
   );
      logic signed [TEN_W-1:0] digit_ext;
      digit_ext = {{(TEN_W-9){digit[8]}}, digit};
      return (acc <<< 3) + (acc <<< 1) + digit_ext;
   endfunction

endpackage

// ===== rtl/core/iso_timestamp_to_epoch.sv =====
// ISO-8601 timestamp text to POSIX seconds, one character per beat.
// Depends on isots_pkg and iso_timestamp_to_epoch_assert.svh.
`include "iso_timestamp_to_epoch_assert.svh"

// While idle the block takes one character beat per cycle and folds it into
// the field accumulators through one shared times-ten adder. The beat marked
// last closes the string: a short or badly separated string returns its
// status (epoch 0) as set in the check state; a well-formed one goes through
// days-from-civil arithmetic on one shared 29x21 multiplier. req_ready is low
// from the last beat until the result beat is taken, then rises the next
// cycle. Division by 400 and by 5 use reciprocal multiplies on that unit.
module iso_timestamp_to_epoch (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  isots_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output isots_pkg::rsp_type  rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_ERA_MUL, S_ERA_BACK, S_YOE, S_DOY_DIV, S_DOY, S_DOE,
      S_DAYS, S_DSEC, S_SUM_SEC, S_SUM_HOUR, S_SUM_MIN, S_SUM_OFFH, S_SUM_OFFM,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_MAIN, PH_TAIL, PH_FRAC, PH_OFFS, PH_DONE
   } phase_type;

   localparam int FW = isots_pkg::FIELD_W;
   localparam int YW = isots_pkg::YEAR_W;
   localparam int PW = isots_pkg::PROD_W;
   localparam int DW = isots_pkg::DAYS_W;

   // Sequencer and output
   state_type           state_ff, state_in;
   isots_pkg::rsp_type  rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Parser state
   phase_type           phase_ff, phase_in;
   logic [4:0]          pos_ff, pos_in;
   logic signed [YW-1:0] year_ff, year_in;
   logic signed [FW-1:0] month_ff, month_in, day_ff, day_in;
   logic signed [FW-1:0] hour_ff, hour_in, minute_ff, minute_in, second_ff, second_in;
   logic signed [FW-1:0] off_hr_ff, off_hr_in, off_min_ff, off_min_in;
   logic                fmt_ok_ff, fmt_ok_in, off_neg_ff, off_neg_in;
   logic [2:0]          off_cnt_ff, off_cnt_in;

   // Conversion datapath
   logic [YW-1:0]       yp_ff, yp_in;
   logic [9:0]          eraq_ff, eraq_in;
   logic [8:0]          yoe_ff, yoe_in;
   logic                neg_ff, neg_in;
   logic signed [DW-1:0] days_ff, days_in;
   logic signed [63:0]  res_ff, res_in;
   logic signed [PW-1:0] prod_ff, prod_in;

   // Shared multiplier operands
   logic signed [isots_pkg::MUL_A_W-1:0] mul_a;
   logic signed [isots_pkg::MUL_B_W-1:0] mul_b;

   // Combinational helpers
   logic                req_accept;
   logic                rsp_failed;
   logic [7:0]          ch;
   logic signed [8:0]   digit;
   logic                sign_ch;
   logic signed [isots_pkg::TEN_W-1:0] ten_acc, ten_out;
   logic                month_le2;
   logic signed [FW-1:0] mo_adj;
   logic signed [isots_pkg::TEN_W-1:0] year_adj, yp_wide;
   logic signed [10:0]  era;
   logic signed [isots_pkg::TEN_W-1:0] doy_num;
   logic [18:0]         doy_mag;
   logic [YW-1:0]       yoe_diff;
   logic [16:0]         q5;
   logic signed [DW-1:0] q5_ext, doy_term;
   logic [1:0]          cent;
   logic signed [63:0]  prod_ext, off_sum;
   logic                off_full;
   logic                clear_parse;

   assign req_accept = req_valid && req_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign rsp_failed = rsp_valid && (rsp_data.status != isots_pkg::ST_OK);

   assign ch      = req_data.character;
   assign digit   = $signed({1'b0, ch}) - $signed(isots_pkg::DIGIT_BIAS);
   assign sign_ch = (ch == isots_pkg::CH_PLUS) || (ch == isots_pkg::CH_DASH);

   // Operand select for the shared times-ten adder
   always_comb begin
      ten_acc = '0;
      if (phase_ff == PH_OFFS) begin
         if (off_cnt_ff < isots_pkg::OFF_HALF) begin
            ten_acc = {{7{off_hr_ff[FW-1]}}, off_hr_ff};
         end else begin
            ten_acc = {{7{off_min_ff[FW-1]}}, off_min_ff};
         end
      end else begin
         case (pos_ff)
            5'd0, 5'd1, 5'd2, 5'd3: ten_acc = {year_ff[YW-1], year_ff};
            5'd5, 5'd6:             ten_acc = {{7{month_ff[FW-1]}}, month_ff};
            5'd8, 5'd9:             ten_acc = {{7{day_ff[FW-1]}}, day_ff};
            5'd11, 5'd12:           ten_acc = {{7{hour_ff[FW-1]}}, hour_ff};
            5'd14, 5'd15:           ten_acc = {{7{minute_ff[FW-1]}}, minute_ff};
            default:                ten_acc = {{7{second_ff[FW-1]}}, second_ff};
         endcase
      end
   end

   assign ten_out = isots_pkg::times_ten_plus(ten_acc, digit);

   // Year shifted into March-based years, biased positive for the /400
   assign month_le2 = (month_ff <= 13'sd2);
   assign mo_adj    = month_le2 ? month_ff + 13'sd9 : month_ff - 13'sd3;
   assign year_adj  = {year_ff[YW-1], year_ff} - (month_le2 ? 20'sd1 : 20'sd0);
   assign yp_wide   = year_adj + isots_pkg::ERA_BIAS_YEARS;
   assign era       = $signed({1'b0, eraq_ff}) - isots_pkg::ERA_BIAS;
   assign yoe_diff  = yp_ff - prod_ff[YW-1:0];

   // (153*m' + 2) as sign and magnitude for the /5 reciprocal
   assign doy_num = prod_ff[isots_pkg::TEN_W-1:0] + 20'sd2;
   assign doy_mag = doy_num[isots_pkg::TEN_W-1] ? 19'(-doy_num) : doy_num[18:0];

   // Truncating quotient back to signed
   assign q5       = prod_ff[isots_pkg::DIV5_SHIFT +: 17];
   assign q5_ext   = $signed({11'd0, q5});
   assign doy_term = neg_ff ? -q5_ext : q5_ext;
   assign cent     = (yoe_ff >= 9'd300) ? 2'd3 :
                     (yoe_ff >= 9'd200) ? 2'd2 :
                     (yoe_ff >= 9'd100) ? 2'd1 : 2'd0;

   assign prod_ext = {{(64-PW){prod_ff[PW-1]}}, prod_ff};
   assign off_sum  = off_neg_ff ? res_ff + prod_ext : res_ff - prod_ext;
   assign off_full = (off_cnt_ff == isots_pkg::OFF_DIGITS);

   // Shared multiplier, registered
   assign prod_in = mul_a * mul_b;

   // Next-state logic: parser, sequencer, datapath
   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      off_hr_in    = off_hr_ff;
      off_min_in   = off_min_ff;
      fmt_ok_in    = fmt_ok_ff;
      off_neg_in   = off_neg_ff;
      off_cnt_in   = off_cnt_ff;
      yp_in        = yp_ff;
      eraq_in      = eraq_ff;
      yoe_in       = yoe_ff;
      neg_in       = neg_ff;
      days_in      = days_ff;
      res_in       = res_ff;
      mul_a        = '0;
      mul_b        = '0;
      clear_parse  = 1'b0;

      // Character parser
      if (req_accept && (phase_ff != PH_DONE)) begin
         if (ch == isots_pkg::CH_NUL) begin
            phase_in = PH_DONE;
         end else begin
            if (pos_ff != isots_pkg::POS_SAT) begin
               pos_in = pos_ff + 5'd1;
            end
            case (phase_ff)
               PH_MAIN: begin
                  case (pos_ff)
                     isots_pkg::POS_DASH1, isots_pkg::POS_DASH2: begin
                        if (ch != isots_pkg::CH_DASH) fmt_ok_in = 1'b0;
                     end
                     isots_pkg::POS_SEP_T: begin
                        if (ch != isots_pkg::CH_T && ch != isots_pkg::CH_SPACE) begin
                           fmt_ok_in = 1'b0;
                        end
                     end
                     isots_pkg::POS_COLON1, isots_pkg::POS_COLON2: begin
                        if (ch != isots_pkg::CH_COLON) fmt_ok_in = 1'b0;
                     end
                     5'd0, 5'd1, 5'd2, 5'd3: year_in   = ten_out[YW-1:0];
                     5'd5, 5'd6:             month_in  = ten_out[FW-1:0];
                     5'd8, 5'd9:             day_in    = ten_out[FW-1:0];
                     5'd11, 5'd12:           hour_in   = ten_out[FW-1:0];
                     5'd14, 5'd15:           minute_in = ten_out[FW-1:0];
                     default:                second_in = ten_out[FW-1:0];
                  endcase
                  if (pos_ff == isots_pkg::POS_LAST_MAIN) phase_in = PH_TAIL;
               end
               PH_TAIL: begin
                  if (ch == isots_pkg::CH_DOT) begin
                     phase_in = PH_FRAC;
                  end else if (sign_ch) begin
                     off_neg_in = (ch == isots_pkg::CH_DASH);
                     phase_in   = PH_OFFS;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_FRAC: begin
                  if (ch < isots_pkg::CH_ZERO || ch > isots_pkg::CH_NINE) begin
                     if (sign_ch) begin
                        off_neg_in = (ch == isots_pkg::CH_DASH);
                        phase_in   = PH_OFFS;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
               end
               PH_OFFS: begin
                  // colon between offset hours and minutes is skipped
                  if (!(off_cnt_ff == isots_pkg::OFF_HALF && ch == isots_pkg::CH_COLON)) begin
                     if (off_cnt_ff < isots_pkg::OFF_HALF) begin
                        off_hr_in = ten_out[FW-1:0];
                     end else begin
                        off_min_in = ten_out[FW-1:0];
                     end
                     off_cnt_in = off_cnt_ff + 3'd1;
                     if (off_cnt_in == isots_pkg::OFF_DIGITS) phase_in = PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // Conversion sequencer
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_data.last) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (pos_ff < isots_pkg::MAIN_LEN) begin
               rsp_in.epoch_seconds = '0;
               rsp_in.status        = isots_pkg::ST_SHORT;
               rsp_valid_in         = 1'b1;
               clear_parse          = 1'b1;
               state_in             = S_OUT;
            end else if (!fmt_ok_ff) begin
               rsp_in.epoch_seconds = '0;
               rsp_in.status        = isots_pkg::ST_BAD_SEP;
               rsp_valid_in         = 1'b1;
               clear_parse          = 1'b1;
               state_in             = S_OUT;
            end else begin
               state_in = S_ERA_MUL;
            end
         end
         S_ERA_MUL: begin
            // biased year times reciprocal of 400
            yp_in    = yp_wide[YW-1:0];
            mul_a    = {10'd0, yp_wide[YW-1:0]};
            mul_b    = isots_pkg::DIV400_MUL;
            state_in = S_ERA_BACK;
         end
         S_ERA_BACK: begin
            eraq_in  = prod_ff[isots_pkg::DIV400_SHIFT +: 10];
            mul_a    = {19'd0, prod_ff[isots_pkg::DIV400_SHIFT +: 10]};
            mul_b    = isots_pkg::YEARS_PER_ERA;
            state_in = S_YOE;
         end
         S_YOE: begin
            yoe_in   = yoe_diff[8:0];
            mul_a    = {{16{mo_adj[FW-1]}}, mo_adj};
            mul_b    = isots_pkg::MONTH_MUL;
            state_in = S_DOY_DIV;
         end
         S_DOY_DIV: begin
            neg_in   = doy_num[isots_pkg::TEN_W-1];
            mul_a    = {10'd0, doy_mag};
            mul_b    = isots_pkg::DIV5_MUL;
            state_in = S_DOY;
         end
         S_DOY: begin
            // doy + yoe/4 - yoe/100 - epoch offset
            days_in  = doy_term + {{(DW-FW){day_ff[FW-1]}}, day_ff} - 28'sd1
                       + $signed({21'd0, yoe_ff[8:2]}) - $signed({26'd0, cent})
                       - isots_pkg::EPOCH_DAY_OFS;
            mul_a    = {20'd0, yoe_ff};
            mul_b    = isots_pkg::DAYS_PER_YEAR;
            state_in = S_DOE;
         end
         S_DOE: begin
            days_in  = days_ff + prod_ff[DW-1:0];
            mul_a    = {{18{era[10]}}, era};
            mul_b    = isots_pkg::DAYS_PER_ERA;
            state_in = S_DAYS;
         end
         S_DAYS: begin
            days_in  = days_ff + prod_ff[DW-1:0];
            state_in = S_DSEC;
         end
         S_DSEC: begin
            mul_a    = {days_ff[DW-1], days_ff};
            mul_b    = isots_pkg::SEC_PER_DAY;
            state_in = S_SUM_SEC;
         end
         S_SUM_SEC: begin
            res_in   = prod_ext + {{(64-FW){second_ff[FW-1]}}, second_ff};
            mul_a    = {{16{hour_ff[FW-1]}}, hour_ff};
            mul_b    = isots_pkg::SEC_PER_HOUR;
            state_in = S_SUM_HOUR;
         end
         S_SUM_HOUR: begin
            res_in   = res_ff + prod_ext;
            mul_a    = {{16{minute_ff[FW-1]}}, minute_ff};
            mul_b    = isots_pkg::SEC_PER_MIN;
            state_in = S_SUM_MIN;
         end
         S_SUM_MIN: begin
            // truncated offset counts as zero
            res_in   = res_ff + prod_ext;
            mul_a    = off_full ? {{16{off_hr_ff[FW-1]}}, off_hr_ff} : '0;
            mul_b    = isots_pkg::SEC_PER_HOUR;
            state_in = S_SUM_OFFH;
         end
         S_SUM_OFFH: begin
            res_in   = off_sum;
            mul_a    = off_full ? {{16{off_min_ff[FW-1]}}, off_min_ff} : '0;
            mul_b    = isots_pkg::SEC_PER_MIN;
            state_in = S_SUM_OFFM;
         end
         S_SUM_OFFM: begin
            rsp_in.epoch_seconds = off_sum;
            rsp_in.status        = isots_pkg::ST_OK;
            rsp_valid_in         = 1'b1;
            clear_parse          = 1'b1;
            state_in             = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Parser back to its start values once a result is formed
      if (clear_parse) begin
         phase_in   = PH_MAIN;
         pos_in     = '0;
         year_in    = '0;
         month_in   = '0;
         day_in     = '0;
         hour_in    = '0;
         minute_in  = '0;
         second_in  = '0;
         off_hr_in  = '0;
         off_min_in = '0;
         fmt_ok_in  = 1'b1;
         off_neg_in = 1'b0;
         off_cnt_in = '0;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_MAIN;
         pos_ff       <= '0;
         year_ff      <= '0;
         month_ff     <= '0;
         day_ff       <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         off_hr_ff    <= '0;
         off_min_ff   <= '0;
         fmt_ok_ff    <= 1'b1;
         off_neg_ff   <= 1'b0;
         off_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         off_hr_ff    <= off_hr_in;
         off_min_ff   <= off_min_in;
         fmt_ok_ff    <= fmt_ok_in;
         off_neg_ff   <= off_neg_in;
         off_cnt_ff   <= off_cnt_in;
         yp_ff        <= yp_in;
         eraq_ff      <= eraq_in;
         yoe_ff       <= yoe_in;
         neg_ff       <= neg_in;
         days_ff      <= days_in;
         res_ff       <= res_in;
         prod_ff      <= prod_in;
      end
   end

   // Checks
   `ITE_ASSERT_NOW(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready)
   `ITE_ASSERT_NOW(a_fail_gives_zero, clock, reset, rsp_failed, rsp_data.epoch_seconds == 64'sd0)
   `ITE_ASSERT_NEXT(a_last_beat_busy, clock, reset, req_accept && req_data.last, !req_ready)
   `ITE_ASSERT_NEXT(a_rsp_taken_idle, clock, reset, rsp_valid && rsp_ready, req_ready && !rsp_valid)

endmodule
